@@ hdl/mohc_pkg.sv @@
// ----------------------------------------------------------------------------
// mohc_pkg - shared definitions for the mains outage hold controller
// Field widths, stream packing, register indexes and register reset values.
// ----------------------------------------------------------------------------
package mohc_pkg;

  // field widths
  localparam int unsigned VoltW = 13;
  localparam int unsigned TimeW = 32;

  // stream packing, padded to whole bytes
  localparam int unsigned InFieldW  = VoltW + TimeW;
  localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = 4 + TimeW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef logic [VoltW-1:0]    volt_t;
  typedef logic [TimeW-1:0]    time_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_ON_THRESHOLD   = 3'd0;
  localparam cfg_idx_t REG_OFF_THRESHOLD  = 3'd1;
  localparam cfg_idx_t REG_PRESENT_DEB    = 3'd2;
  localparam cfg_idx_t REG_ABSENT_DEB     = 3'd3;
  localparam cfg_idx_t REG_BOOT_ARM       = 3'd4;
  localparam cfg_idx_t REG_SHUTDOWN_AFTER = 3'd5;
  localparam cfg_idx_t REG_BOOT_TIME      = 3'd6;
  localparam cfg_idx_t REG_PIN_FITTED     = 3'd7;

  // register reset values
  localparam volt_t RST_ON_THRESHOLD   = 13'd1440;
  localparam volt_t RST_OFF_THRESHOLD  = 13'd1120;
  localparam time_t RST_PRESENT_DEB    = 32'd500;
  localparam time_t RST_ABSENT_DEB     = 32'd200;
  localparam time_t RST_BOOT_ARM       = 32'd5000;
  localparam time_t RST_SHUTDOWN_AFTER = 32'd30000;
  localparam time_t RST_BOOT_TIME      = 32'd0;
  localparam logic  RST_PIN_FITTED     = 1'b1;

  // timestamp value that means not captured
  localparam time_t TIME_UNSET = 32'd0;

endpackage

@@ hdl/mains_outage_hold_controller_core.sv @@
// ----------------------------------------------------------------------------
// mains_outage_hold_controller_core - mains presence qualifier and hold timer
// Debounces mains presence with hysteresis, times outages after boot arming
// and latches a shutdown that drops the hold enable.
// ----------------------------------------------------------------------------
// Timing: a sample passes the input register, then the result register, before
// out_tvalid rises; a stalled result register holds it back.
// Throughput: one sample per cycle while the result stream is not stalled, set by the single decision stage.
// Reset: rst_n synchronous, active low; clears control state and loads
// every configuration register with its default value.
module mains_outage_hold_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [12:0] vrms_sample, [44:13] now_ms, [47:45] zero
  input  logic [mohc_pkg::InDataW-1:0]    in_tdata,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] enable_level, [1] mains_ok, [2] outage_flag,
  // [34:3] outage_elapsed_ms, [35] shutdown_latched, [39:36] zero
  output logic [mohc_pkg::OutDataW-1:0]   out_tdata,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mohc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mohc_pkg::CfgDataW-1:0]   cfg_data
);

  localparam int unsigned InPadW  = mohc_pkg::InDataW - mohc_pkg::InFieldW;
  localparam int unsigned OutPadW = mohc_pkg::OutDataW - mohc_pkg::OutFieldW;

  // configuration registers
  mohc_pkg::volt_t on_thr_r, off_thr_r;
  mohc_pkg::time_t pres_deb_r, abs_deb_r, boot_arm_r, sd_after_r, boot_time_r;
  logic            pin_fitted_r;

  // controller state
  logic            present_r, seen_r, running_r, sd_done_r;
  mohc_pkg::time_t pres_since_r, abs_since_r, out_start_r;

  // input stage
  logic            s1_valid_r;
  mohc_pkg::volt_t s1_volt_r;
  mohc_pkg::time_t s1_now_r;

  // result stage
  logic                                out_valid_r;
  logic [mohc_pkg::OutFieldW-1:0]      out_fields_r;

  // next state
  logic            present_nxt, seen_nxt, running_nxt, sd_done_nxt;
  mohc_pkg::time_t pres_since_nxt, abs_since_nxt, out_start_nxt;
  logic [mohc_pkg::OutFieldW-1:0] out_fields_nxt;

  logic s1_adv;
  logic s1_fire;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thr_r     <= mohc_pkg::RST_ON_THRESHOLD;
      off_thr_r    <= mohc_pkg::RST_OFF_THRESHOLD;
      pres_deb_r   <= mohc_pkg::RST_PRESENT_DEB;
      abs_deb_r    <= mohc_pkg::RST_ABSENT_DEB;
      boot_arm_r   <= mohc_pkg::RST_BOOT_ARM;
      sd_after_r   <= mohc_pkg::RST_SHUTDOWN_AFTER;
      boot_time_r  <= mohc_pkg::RST_BOOT_TIME;
      pin_fitted_r <= mohc_pkg::RST_PIN_FITTED;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mohc_pkg::REG_ON_THRESHOLD:   on_thr_r     <= cfg_data[mohc_pkg::VoltW-1:0];
        mohc_pkg::REG_OFF_THRESHOLD:  off_thr_r    <= cfg_data[mohc_pkg::VoltW-1:0];
        mohc_pkg::REG_PRESENT_DEB:    pres_deb_r   <= cfg_data[mohc_pkg::TimeW-1:0];
        mohc_pkg::REG_ABSENT_DEB:     abs_deb_r    <= cfg_data[mohc_pkg::TimeW-1:0];
        mohc_pkg::REG_BOOT_ARM:       boot_arm_r   <= cfg_data[mohc_pkg::TimeW-1:0];
        mohc_pkg::REG_SHUTDOWN_AFTER: sd_after_r   <= cfg_data[mohc_pkg::TimeW-1:0];
        mohc_pkg::REG_BOOT_TIME:      boot_time_r  <= cfg_data[mohc_pkg::TimeW-1:0];
        mohc_pkg::REG_PIN_FITTED:     pin_fitted_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline flow: the decision stage moves when the result slot is free
  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_volt_r <= in_tdata[mohc_pkg::VoltW-1:0];
      s1_now_r  <= in_tdata[mohc_pkg::InFieldW-1:mohc_pkg::VoltW];
    end
  end

  // presence qualification, outage timing and shutdown decision
  always_comb begin
    logic            armed;
    logic            mains_now;
    logic            check_sd;
    mohc_pkg::time_t now;
    mohc_pkg::time_t pres_eff;
    mohc_pkg::time_t abs_eff;
    mohc_pkg::time_t elapsed;

    now      = s1_now_r;
    armed    = (now - boot_time_r) >= boot_arm_r;
    mains_now = present_r ? ({1'b0, s1_volt_r} > {1'b0, off_thr_r})
                          : (s1_volt_r >= on_thr_r);
    pres_eff = (pres_since_r == mohc_pkg::TIME_UNSET) ? now : pres_since_r;
    abs_eff  = (abs_since_r == mohc_pkg::TIME_UNSET) ? now : abs_since_r;

    present_nxt    = present_r;
    seen_nxt       = seen_r;
    running_nxt    = running_r;
    sd_done_nxt    = sd_done_r;
    pres_since_nxt = pres_since_r;
    abs_since_nxt  = abs_since_r;
    out_start_nxt  = out_start_r;
    check_sd       = 1'b0;

    if (!sd_done_r) begin
      if (mains_now) begin
        abs_since_nxt = mohc_pkg::TIME_UNSET;
        if (!present_r) begin
          pres_since_nxt = pres_eff;
          if ((now - pres_eff) >= pres_deb_r) begin
            present_nxt   = 1'b1;
            seen_nxt      = 1'b1;
            running_nxt   = 1'b0;
            out_start_nxt = '0;
          end
        end else begin
          pres_since_nxt = now;
          running_nxt    = 1'b0;
          out_start_nxt  = '0;
        end
      end else begin
        pres_since_nxt = mohc_pkg::TIME_UNSET;
        if (present_r) begin
          abs_since_nxt = abs_eff;
          check_sd      = 1'b1;
          if ((now - abs_eff) >= abs_deb_r) begin
            present_nxt = 1'b0;
            if (armed && seen_r) begin
              running_nxt   = 1'b1;
              out_start_nxt = now;
            end
          end
        end else if (seen_r && armed) begin
          abs_since_nxt = abs_eff;
          check_sd      = 1'b1;
          if (!running_r && ((now - abs_eff) >= abs_deb_r)) begin
            running_nxt   = 1'b1;
            out_start_nxt = now;
          end
        end
      end
    end

    elapsed = now - out_start_nxt;

    // outage long enough: latch shutdown when the pin is fitted
    if (check_sd && running_nxt && (elapsed >= sd_after_r) && pin_fitted_r) begin
      sd_done_nxt = 1'b1;
    end

    out_fields_nxt = {sd_done_nxt,
                      running_nxt ? elapsed : mohc_pkg::time_t'(0),
                      running_nxt,
                      present_nxt,
                      pin_fitted_r && !sd_done_nxt};
  end

  // state update on each processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r    <= 1'b0;
      seen_r       <= 1'b0;
      running_r    <= 1'b0;
      sd_done_r    <= 1'b0;
      pres_since_r <= mohc_pkg::TIME_UNSET;
      abs_since_r  <= mohc_pkg::TIME_UNSET;
      out_start_r  <= '0;
    end else if (s1_fire) begin
      present_r    <= present_nxt;
      seen_r       <= seen_nxt;
      running_r    <= running_nxt;
      sd_done_r    <= sd_done_nxt;
      pres_since_r <= pres_since_nxt;
      abs_since_r  <= abs_since_nxt;
      out_start_r  <= out_start_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_fields_r <= out_fields_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OutPadW{1'b0}}, out_fields_r};

  // padding bits of the input word carry nothing
  logic [InPadW-1:0] in_pad_unused;
  assign in_pad_unused = in_tdata[mohc_pkg::InDataW-1:mohc_pkg::InFieldW];

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - mains outage hold controller core
// Streams timestamped voltage samples through the core under several register
// settings and stall patterns, predicts every result with a behavioral model
// of the presence debounce, outage timer and shutdown latch, and checks each
// result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import mohc_pkg::*;

  localparam int VoltMax    = (1 << VoltW) - 1;
  localparam int LongHold   = 400;
  localparam int StallLimit = 3000;
  localparam int LeadRun    = 15;

  typedef enum {LVL_HIGH, LVL_LOW, LVL_BAND, LVL_EDGE, LVL_NOISE} volt_kind_t;

  typedef struct {
    volt_t volt;
    time_t now;
  } sample_t;

  typedef struct {
    logic  enable;
    logic  mains_ok;
    logic  outage;
    time_t elapsed;
    logic  shut;
  } hold_result_t;

  typedef struct {
    volt_t on_th;
    volt_t off_th;
    time_t pres_deb;
    time_t abs_deb;
    time_t arm_ms;
    time_t shut_ms;
    time_t boot_ms;
    logic  pin;
  } hold_cfg_t;

  typedef struct {
    logic  present;
    logic  seen;
    logic  outage;
    logic  shut;
    time_t present_since;
    time_t absent_since;
    time_t outage_start;
  } hold_state_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  cfg_idx_t            cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  hold_cfg_t    hcfg;
  hold_state_t  hst;
  sample_t      sample_q[$];
  hold_result_t hold_expect_q[$];
  sample_t      tx_sample;
  hold_result_t got_r;
  hold_result_t want_r;
  bit           offering      = 1'b0;
  bit           hold_req      = 1'b0;
  int           hold_left     = 0;
  int           send_idle_pct = 0;
  int           rx_stall_pct  = 0;
  int           fail_count    = 0;
  int           idle_cycles   = 0;
  time_t        stamp_ms      = '0;

  mains_outage_hold_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // behavioral hold logic: updates the model state, returns the result
  function automatic hold_result_t predict_hold(volt_t v, time_t now);
    hold_result_t r;
    logic armed;
    logic mains_now;
    logic check_shut;
    armed      = time_t'(now - hcfg.boot_ms) >= hcfg.arm_ms;
    mains_now  = hst.present ? (v > hcfg.off_th) : (v >= hcfg.on_th);
    check_shut = 1'b0;
    // a latched shutdown freezes the state
    if (!hst.shut) begin
      if (mains_now) begin
        hst.absent_since = TIME_UNSET;
        if (!hst.present) begin
          if (hst.present_since == TIME_UNSET) hst.present_since = now;
          if (time_t'(now - hst.present_since) >= hcfg.pres_deb) begin
            hst.present      = 1'b1;
            hst.seen         = 1'b1;
            hst.outage       = 1'b0;
            hst.outage_start = '0;
          end
        end else begin
          hst.present_since = now;
          hst.outage        = 1'b0;
          hst.outage_start  = '0;
        end
      end else begin
        hst.present_since = TIME_UNSET;
        if (hst.present) begin
          if (hst.absent_since == TIME_UNSET) hst.absent_since = now;
          if (time_t'(now - hst.absent_since) >= hcfg.abs_deb) begin
            hst.present = 1'b0;
            if (armed && hst.seen) begin
              hst.outage       = 1'b1;
              hst.outage_start = now;
            end
          end
          check_shut = 1'b1;
        end else if (hst.seen && armed) begin
          if (hst.absent_since == TIME_UNSET) hst.absent_since = now;
          if (!hst.outage && time_t'(now - hst.absent_since) >= hcfg.abs_deb) begin
            hst.outage       = 1'b1;
            hst.outage_start = now;
          end
          check_shut = 1'b1;
        end
      end
      // outage long enough: latch shutdown when the pin exists
      if (check_shut && hst.outage && hcfg.pin &&
          time_t'(now - hst.outage_start) >= hcfg.shut_ms) begin
        hst.shut = 1'b1;
      end
    end
    r.enable   = hcfg.pin && !hst.shut;
    r.mains_ok = hst.present;
    r.outage   = hst.outage;
    r.elapsed  = hst.outage ? time_t'(now - hst.outage_start) : '0;
    r.shut     = hst.shut;
    return r;
  endfunction

  // voltage relative to the current thresholds
  function automatic volt_t pick_volt(volt_kind_t kind);
    int on_i;
    int off_i;
    int hi_lo;
    int lo_hi;
    on_i  = hcfg.on_th;
    off_i = hcfg.off_th;
    hi_lo = (on_i > off_i + 1) ? on_i : off_i + 1;
    if (hi_lo > VoltMax) hi_lo = VoltMax;
    lo_hi = (off_i < on_i - 1) ? off_i : on_i - 1;
    if (lo_hi < 0) lo_hi = 0;
    case (kind)
      LVL_HIGH: return volt_t'($urandom_range(VoltMax, hi_lo));
      LVL_LOW:  return volt_t'($urandom_range(lo_hi, 0));
      LVL_BAND: return volt_t'($urandom_range(on_i, off_i));
      LVL_EDGE: begin
        case ($urandom_range(5))
          0:       return hcfg.on_th;
          1:       return hcfg.on_th - 1'b1;
          2:       return hcfg.off_th;
          3:       return hcfg.off_th + 1'b1;
          4:       return '0;
          default: return volt_t'(VoltMax);
        endcase
      end
      default:  return volt_t'($urandom_range(VoltMax));
    endcase
  endfunction

  // advance the stamp, landing exactly on zero when it wraps
  function automatic void bump_stamp(time_t step);
    time_t nxt;
    nxt = stamp_ms + step;
    if (nxt < stamp_ms) nxt = TIME_UNSET;
    stamp_ms = nxt;
  endfunction

  task automatic push_run(input int count, input volt_kind_t kind, input time_t step);
    for (int i = 0; i < count; i++) begin
      bump_stamp(step);
      sample_q.push_back('{pick_volt(kind), stamp_ms});
    end
  endtask

  // lead-in that declares mains present, then random segments
  task automatic fill_random(input int n, input int max_step, input int seg_max,
                             input bit jumps);
    int         left;
    int         seg;
    int         pick;
    volt_kind_t kind;
    time_t      step;
    push_run(LeadRun, LVL_HIGH, 4);
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 30)      kind = LVL_HIGH;
      else if (pick < 60) kind = LVL_LOW;
      else if (pick < 70) kind = LVL_BAND;
      else if (pick < 85) kind = LVL_EDGE;
      else                kind = LVL_NOISE;
      seg = $urandom_range(seg_max, 1);
      for (int i = 0; i < seg && left > 0; i++) begin
        if (jumps && $urandom_range(99) < 3) step = $urandom;
        else if ($urandom_range(99) < 3)     step = '0;
        else                                 step = $urandom_range(max_step, 1);
        bump_stamp(step);
        // occasional glitch inside a segment may restart the debounce
        if ($urandom_range(99) < 5) sample_q.push_back('{pick_volt(LVL_NOISE), stamp_ms});
        else                        sample_q.push_back('{pick_volt(kind), stamp_ms});
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || offering || hold_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ON_THRESHOLD:   hcfg.on_th    = val[VoltW-1:0];
      REG_OFF_THRESHOLD:  hcfg.off_th   = val[VoltW-1:0];
      REG_PRESENT_DEB:    hcfg.pres_deb = val;
      REG_ABSENT_DEB:     hcfg.abs_deb  = val;
      REG_BOOT_ARM:       hcfg.arm_ms   = val;
      REG_SHUTDOWN_AFTER: hcfg.shut_ms  = val;
      REG_BOOT_TIME:      hcfg.boot_ms  = val;
      REG_PIN_FITTED:     hcfg.pin      = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic start_phase(input volt_t on_th, input volt_t off_th, input time_t pres_deb,
                             input time_t abs_deb, input time_t arm_ms, input time_t shut_ms,
                             input time_t boot_ms, input logic pin, input int send_pct,
                             input int rx_pct);
    wait_drained();
    write_reg(REG_ON_THRESHOLD,   CfgDataW'(on_th));
    write_reg(REG_OFF_THRESHOLD,  CfgDataW'(off_th));
    write_reg(REG_PRESENT_DEB,    pres_deb);
    write_reg(REG_ABSENT_DEB,     abs_deb);
    write_reg(REG_BOOT_ARM,       arm_ms);
    write_reg(REG_SHUTDOWN_AFTER, shut_ms);
    write_reg(REG_BOOT_TIME,      boot_ms);
    write_reg(REG_PIN_FITTED,     CfgDataW'(pin));
    send_idle_pct = send_pct;
    rx_stall_pct  = rx_pct;
  endtask

  // input driver: offers queued samples, predicts the result of each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        hold_expect_q.push_back(predict_hold(tx_sample.volt, tx_sample.now));
        offering = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tx_sample = sample_q.pop_front();
          offering  = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata  <= InDataW'({tx_sample.now, tx_sample.volt});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_r.enable   = out_tdata[0];
        got_r.mains_ok = out_tdata[1];
        got_r.outage   = out_tdata[2];
        got_r.elapsed  = out_tdata[3 +: TimeW];
        got_r.shut     = out_tdata[3 + TimeW];
        if (hold_expect_q.size() == 0) begin
          $error("result transfer with no sample outstanding");
          fail_count++;
        end else begin
          want_r = hold_expect_q.pop_front();
          if (got_r.enable !== want_r.enable) begin
            $error("enable_level: expected %0d, got %0d", want_r.enable, got_r.enable);
            fail_count++;
          end
          if (got_r.mains_ok !== want_r.mains_ok) begin
            $error("mains_ok: expected %0d, got %0d", want_r.mains_ok, got_r.mains_ok);
            fail_count++;
          end
          if (got_r.outage !== want_r.outage) begin
            $error("outage_flag: expected %0d, got %0d", want_r.outage, got_r.outage);
            fail_count++;
          end
          if (got_r.elapsed !== want_r.elapsed) begin
            $error("outage_elapsed_ms: expected %0d, got %0d", want_r.elapsed, got_r.elapsed);
            fail_count++;
          end
          if (got_r.shut !== want_r.shut) begin
            $error("shutdown_latched: expected %0d, got %0d", want_r.shut, got_r.shut);
            fail_count++;
          end
        end
      end
      // long hold-off on request, random stalls otherwise
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus sequence
  initial begin
    hcfg = '{RST_ON_THRESHOLD, RST_OFF_THRESHOLD, RST_PRESENT_DEB, RST_ABSENT_DEB,
             RST_BOOT_ARM, RST_SHUTDOWN_AFTER, RST_BOOT_TIME, RST_PIN_FITTED};
    hst  = '{default: '0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: threshold edges, debounce, arming, wrap to zero
    sample_q.push_back('{13'd8191, 32'd0});          // mains at stamp zero, stays unset
    sample_q.push_back('{13'd1440, 32'd100});        // exactly on threshold
    sample_q.push_back('{13'd1439, 32'd300});        // just below
    sample_q.push_back('{13'd1440, 32'd400});
    sample_q.push_back('{13'd1500, 32'd900});        // present after debounce
    sample_q.push_back('{13'd1121, 32'd1000});       // just above off, holds
    sample_q.push_back('{13'd1120, 32'd1100});       // exactly off, absent starts
    sample_q.push_back('{13'd0, 32'd1400});          // absent, boot delay not over
    sample_q.push_back('{13'd0, 32'd6000});          // armed, outage starts
    sample_q.push_back('{13'd0, 32'd20000});
    sample_q.push_back('{13'd1440, 32'd21000});      // brief return, not debounced
    sample_q.push_back('{13'd0, 32'd21100});
    sample_q.push_back('{13'd8191, 32'hFFFF_FF00});
    sample_q.push_back('{13'd8191, 32'd0});          // stamp wraps to zero
    sample_q.push_back('{13'd8191, 32'd500});        // present across the wrap
    sample_q.push_back('{13'd4096, 32'd600});
    sample_q.push_back('{13'd2047, 32'd700});
    stamp_ms = 32'd700;

    // nominal thresholds, short times, no idling
    start_phase(13'd1440, 13'd1120, 32'd20, 32'd15, 32'd50, 32'h1000_0000, stamp_ms,
                1'b1, 0, 0);
    fill_random(170, 8, 25, 1'b0);

    // extreme thresholds, zero debounce and arming, stamps crossing the wrap
    start_phase(13'd8191, 13'd0, 32'd0, 32'd0, 32'd0, 32'h1000_0000, 32'hFFFF_FFFF,
                1'b1, 77, 0);
    stamp_ms = 32'hFFFF_FF80;
    fill_random(150, 8, 25, 1'b0);

    // no pin fitted, inverted thresholds, big stamp jumps
    start_phase(13'd0, 13'd8191, 32'd30, 32'd25, 32'hFFFF_FFFF, 32'd0, 32'd0,
                1'b0, 0, 77);
    fill_random(150, 10, 25, 1'b1);

    // boot stamp ahead of now, long receiver hold-off, sender pause
    start_phase(13'd1600, 13'd1000, 32'd10, 32'd8, 32'd30, 32'h1000_0000,
                stamp_ms + 32'd20, 1'b1, 7, 7);
    fill_random(90, 6, 30, 1'b0);
    hold_req = 1'b1;
    wait_drained();
    fill_random(90, 6, 30, 1'b0);

    // short shutdown time, ends with a forced outage and frozen state
    start_phase(13'd1440, 13'd1120, 32'd12, 32'd10, 32'd20, 32'd80, stamp_ms,
                1'b1, 7, 7);
    fill_random(120, 6, 40, 1'b0);
    push_run(LeadRun, LVL_HIGH, 4);
    push_run(40, LVL_LOW, 5);
    push_run(20, LVL_NOISE, 5);
    wait_drained();

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ mains_outage_hold_controller_core.f @@
hdl/mohc_pkg.sv
hdl/mains_outage_hold_controller_core.sv
verif/testbench.sv
